### rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge and off while reset is held.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("%m: property failed");

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	`ASSERT_PROP(lbl, clk, rstn, (ante) |-> (cons))

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	`ASSERT_PROP(lbl, clk, rstn, (ante) |=> (cons))

`endif

### rtl/krt_pkg.sv
// Shared types, widths and helper functions of the keyed record table.
// No dependencies; the modules and interfaces of the block use it.
package krt_pkg;

	localparam int SLOTS_DEF = 128;
	localparam int OP_W      = 2;
	localparam int KEY_W     = 32;
	localparam int AMT_W     = 32;
	localparam int ST_W      = 2;
	localparam int SLOT_W    = 7;
	localparam int COUNT_W   = 8;
	localparam int TOTAL_W   = 39;

	typedef enum logic [OP_W-1:0] {
		OP_ADD    = 2'd0,
		OP_FIND   = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_HIT,
		S_MOVE,
		S_RESP
	} state_t;

	// Control of the shared accumulator.
	typedef struct packed {
		logic en;
		logic sub;
		logic clr;
	} acc_ctl_t;

	function automatic logic [TOTAL_W-1:0] widen_amount(input logic [AMT_W-1:0] a);
		return {{(TOTAL_W-AMT_W){a[AMT_W-1]}}, a};
	endfunction

endpackage

### rtl/krt_req_if.sv
// Request channel of the keyed record table: valid/ready plus one request item.
// Depends on krt_pkg for the field widths.
interface krt_req_if;
	logic                               valid;
	logic                               ready;
	logic [krt_pkg::OP_W-1:0]           operation;
	logic signed [krt_pkg::KEY_W-1:0]   key;
	logic signed [krt_pkg::AMT_W-1:0]   amount;

	modport source (output valid, output operation, output key, output amount, input ready);
	modport sink   (input valid, input operation, input key, input amount, output ready);
endinterface

### rtl/krt_rsp_if.sv
// Response channel of the keyed record table: valid/ready plus one result item.
// Depends on krt_pkg for the field widths.
interface krt_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic [krt_pkg::ST_W-1:0]             status;
	logic [krt_pkg::SLOT_W-1:0]           slot_index;
	logic signed [krt_pkg::AMT_W-1:0]     found_amount;
	logic [krt_pkg::COUNT_W-1:0]          count_in_use;
	logic signed [krt_pkg::TOTAL_W-1:0]   total_amount;

	modport source (output valid, output status, output slot_index, output found_amount,
		output count_in_use, output total_amount, input ready);
	modport sink   (input valid, input status, input slot_index, input found_amount,
		input count_in_use, input total_amount, output ready);
endinterface

### rtl/krt_total.sv
// Running total of all stored amounts, with the one shared add/subtract unit.
// Depends on krt_pkg.
module krt_total (
	input  logic                               clk,
	input  logic                               arst_n,
	input  krt_pkg::acc_ctl_t                  ctl,
	input  logic [krt_pkg::AMT_W-1:0]          operand,
	output logic signed [krt_pkg::TOTAL_W-1:0] total
);
	import krt_pkg::*;

	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W-1:0] addend;

	// Subtraction is done as adding the complement plus one.
	assign addend = ctl.sub ? ~widen_amount(operand) : widen_amount(operand);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (ctl.clr) begin
			total_q <= '0;
		end else if (ctl.en) begin
			total_q <= total_q + addend + TOTAL_W'(ctl.sub);
		end
	end

	assign total = total_q;

endmodule

### rtl/keyed_record_table.sv
// Keyed record table top level: request/response channels, record memories, sequencer.
// Depends on krt_pkg, krt_req_if, krt_rsp_if and krt_total.
//
// Usage: a request item on req carries an operation (add, find, remove, clear),
// a key and an amount. Exactly one result item per request leaves on rsp, with
// a status, the slot concerned, the found amount, the record count and the
// running total of all stored amounts.
// The block takes one request at a time; req.ready is high only while idle.
// An add or clear passes through the execute state to the response state; a find
// scans to the hit state and then responds, and a remove also passes the move
// state; a miss ends the scan at the last record, and a find or remove on an
// empty table goes straight to the response state.
// A scan compares one stored key per cycle against the request key, reading
// the key memory through its single registered read port, so a full scan of
// SLOTS records sets the worst case.
// The result sits in an output register; if rsp.ready is low the block holds
// it and waits, and takes no new request until the result has been loaded.
// Reset empties the table (count and total zero) at once; the memories need
// no clearing since only slots below the count are ever used.
module keyed_record_table #(
	parameter int SLOTS = krt_pkg::SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	krt_req_if.sink   req,
	krt_rsp_if.source rsp
);
	import krt_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	logic [KEY_W-1:0] key_mem [SLOTS];
	logic [AMT_W-1:0] amt_mem [SLOTS];

	state_t            state_q, state_d;
	op_t               op_q;
	logic [KEY_W-1:0]  key_q;
	logic [AMT_W-1:0]  amount_q;
	logic [CW-1:0]     count_q;
	logic [IW-1:0]     idx_q;
	logic [IW-1:0]     slot_q;
	logic [KEY_W-1:0]  key_hold_q;
	status_t           status_q;
	logic [AMT_W-1:0]  found_q;
	logic [KEY_W-1:0]  key_rd_q;
	logic [AMT_W-1:0]  amt_rd_q;

	logic                rsp_valid_q;
	logic [ST_W-1:0]     rsp_status_q;
	logic [SLOT_W-1:0]   rsp_slot_q;
	logic [AMT_W-1:0]    rsp_found_q;
	logic [COUNT_W-1:0]  rsp_count_q;
	logic [TOTAL_W-1:0]  rsp_total_q;

	logic              accept;
	logic              full;
	logic              hit;
	logic              scan_last;
	logic [IW-1:0]     last_idx;
	logic [IW-1:0]     key_raddr;
	logic [IW-1:0]     amt_raddr;
	logic              mem_we;
	logic [IW-1:0]     waddr;
	logic [KEY_W-1:0]  wkey;
	logic [AMT_W-1:0]  wamt;
	logic              rsp_load;
	acc_ctl_t          acc_ctl;
	logic [AMT_W-1:0]  acc_operand;
	logic signed [TOTAL_W-1:0] total;
	logic [31:0]       slot_wide;
	logic [31:0]       count_wide;

	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CW'(SLOTS));
	assign hit       = (key_rd_q == key_q);
	assign scan_last = ((CW'(idx_q) + CW'(1)) == count_q);
	assign last_idx  = IW'(count_q - CW'(1));
	assign slot_wide  = 32'(slot_q);
	assign count_wide = 32'(count_q);

	assign req.ready = (state_q == S_IDLE);

	always_comb begin
		state_d     = state_q;
		key_raddr   = '0;
		amt_raddr   = slot_q;
		mem_we      = 1'b0;
		waddr       = count_q[IW-1:0];
		wkey        = key_q;
		wamt        = amount_q;
		acc_ctl     = '0;
		acc_operand = amount_q;
		rsp_load    = 1'b0;
		case (state_q)
			S_IDLE: begin
				// Slot 0 is read every idle cycle so a scan can start right away.
				if (req.valid) begin
					case (op_t'(req.operation))
						OP_ADD, OP_CLEAR: state_d = S_EXEC;
						OP_FIND, OP_REMOVE: state_d = (count_q == '0) ? S_RESP : S_SCAN;
						default: state_d = S_EXEC;
					endcase
				end
			end
			S_EXEC: begin
				if (op_q == OP_CLEAR) begin
					acc_ctl.clr = 1'b1;
				end else if (!full) begin
					mem_we     = 1'b1;
					acc_ctl.en = 1'b1;
				end
				state_d = S_RESP;
			end
			S_SCAN: begin
				if (hit) begin
					amt_raddr = idx_q;
					key_raddr = last_idx;
					state_d   = S_HIT;
				end else if (scan_last) begin
					state_d = S_RESP;
				end else begin
					key_raddr = idx_q + IW'(1);
				end
			end
			S_HIT: begin
				if (op_q == OP_FIND) begin
					state_d = S_RESP;
				end else begin
					acc_ctl.en  = 1'b1;
					acc_ctl.sub = 1'b1;
					acc_operand = amt_rd_q;
					amt_raddr   = last_idx;
					state_d     = S_MOVE;
				end
			end
			S_MOVE: begin
				// The last record fills the freed slot, keeping the table packed.
				mem_we  = 1'b1;
				waddr   = slot_q;
				wkey    = key_hold_q;
				wamt    = amt_rd_q;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_EXEC) begin
				if (op_q == OP_CLEAR) begin
					count_q <= '0;
				end else if (!full) begin
					count_q <= count_q + CW'(1);
				end
			end else if (state_q == S_MOVE) begin
				count_q <= count_q - CW'(1);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op_t'(req.operation);
			key_q    <= req.key;
			amount_q <= req.amount;
			slot_q   <= '0;
			found_q  <= '0;
			idx_q    <= '0;
			if ((op_t'(req.operation) == OP_FIND || op_t'(req.operation) == OP_REMOVE)
					&& count_q == '0) begin
				status_q <= ST_MISS;
			end else begin
				status_q <= ST_OK;
			end
		end
		case (state_q)
			S_EXEC: begin
				if (op_q == OP_ADD) begin
					if (full) begin
						status_q <= ST_FULL;
					end else begin
						slot_q <= count_q[IW-1:0];
					end
				end
			end
			S_SCAN: begin
				if (hit) begin
					slot_q <= idx_q;
				end else if (scan_last) begin
					status_q <= ST_MISS;
				end else begin
					idx_q <= idx_q + IW'(1);
				end
			end
			S_HIT: begin
				if (op_q == OP_FIND) begin
					found_q <= amt_rd_q;
				end
				key_hold_q <= key_rd_q;
			end
			default: ;
		endcase
		if (rsp_load) begin
			rsp_status_q <= status_q;
			rsp_slot_q   <= slot_wide[SLOT_W-1:0];
			rsp_found_q  <= found_q;
			rsp_count_q  <= count_wide[COUNT_W-1:0];
			rsp_total_q  <= total;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[waddr] <= wkey;
			amt_mem[waddr] <= wamt;
		end
		key_rd_q <= key_mem[key_raddr];
		amt_rd_q <= amt_mem[amt_raddr];
	end

	krt_total u_total (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (acc_ctl),
		.operand (acc_operand),
		.total   (total)
	);

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.slot_index   = rsp_slot_q;
	assign rsp.found_amount = rsp_found_q;
	assign rsp.count_in_use = rsp_count_q;
	assign rsp.total_amount = rsp_total_q;

endmodule

### rtl/krt_checker.sv
// Port-level checks of the keyed record table, bound to the top level.
// Depends on krt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module krt_props #(
	parameter int SLOTS = krt_pkg::SLOTS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [krt_pkg::ST_W-1:0]      rsp_status,
	input logic [krt_pkg::SLOT_W-1:0]    rsp_slot_index,
	input logic [krt_pkg::AMT_W-1:0]     rsp_found_amount,
	input logic [krt_pkg::COUNT_W-1:0]   rsp_count_in_use,
	input logic [krt_pkg::TOTAL_W-1:0]   rsp_total_amount
);
	import krt_pkg::*;

	localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(SLOTS);

	// A request keeps the block busy for at least the following cycle.
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready)

	// A full table reports all slots in use and no slot or amount.
	`ASSERT_IMPL(a_full_result, clk, arst_n,
		rsp_valid && rsp_status == ST_FULL,
		rsp_count_in_use == FULL_COUNT && rsp_slot_index == '0 && rsp_found_amount == '0)

	// A miss carries no slot and no amount.
	`ASSERT_IMPL(a_miss_result, clk, arst_n,
		rsp_valid && rsp_status == ST_MISS,
		rsp_slot_index == '0 && rsp_found_amount == '0)

	// An empty table holds a zero total.
	`ASSERT_IMPL(a_empty_total, clk, arst_n,
		rsp_valid && SLOTS < 256 && rsp_count_in_use == '0,
		rsp_total_amount == '0)

	// A stalled result keeps its total.
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n,
		rsp_valid && !rsp_ready,
		rsp_valid && $stable(rsp_total_amount))

endmodule

bind keyed_record_table krt_props #(.SLOTS(SLOTS)) u_krt_props (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_slot_index   (rsp.slot_index),
	.rsp_found_amount (rsp.found_amount),
	.rsp_count_in_use (rsp.count_in_use),
	.rsp_total_amount (rsp.total_amount)
);

### tb/krt_checker.sv
// Checker for the keyed record table: watches the request and response channels,
// predicts each result from its own copy of the table and compares field by field.
// Depends on krt_pkg, krt_req_if and krt_rsp_if.
module krt_checker (
	input  logic        clk,
	input  logic        arst_n,
	krt_req_if          req,
	krt_rsp_if          rsp,
	output int unsigned mismatches,
	output int          pending,
	output int unsigned hit_count,
	output int unsigned full_count
);
	import krt_pkg::*;

	typedef struct {
		status_t                     status;
		logic [SLOT_W-1:0]           slot_index;
		logic signed [AMT_W-1:0]     found_amount;
		logic [COUNT_W-1:0]          count_in_use;
		logic signed [TOTAL_W-1:0]   total_amount;
	} table_result_t;

	logic [KEY_W-1:0]          key_mem [SLOTS_DEF];
	logic [AMT_W-1:0]          amt_mem [SLOTS_DEF];
	int                        used;
	logic signed [TOTAL_W-1:0] sum;
	table_result_t             results_due [$];

	// Applies one request to the shadow table and returns the result it should give.
	function automatic table_result_t apply_request(input op_t op, input logic [KEY_W-1:0] k,
			input logic [AMT_W-1:0] a);
		table_result_t r;
		int            pos;
		r.status       = ST_OK;
		r.slot_index   = '0;
		r.found_amount = '0;
		pos = -1;
		for (int i = 0; i < used; i++) begin
			if (pos < 0 && key_mem[i] == k)
				pos = i;
		end
		case (op)
			OP_ADD: begin
				if (used >= SLOTS_DEF) begin
					r.status = ST_FULL;
					full_count++;
				end else begin
					r.slot_index  = used[SLOT_W-1:0];
					key_mem[used] = k;
					amt_mem[used] = a;
					used++;
					sum = sum + {{(TOTAL_W-AMT_W){a[AMT_W-1]}}, a};
				end
			end
			OP_FIND: begin
				if (pos < 0) begin
					r.status = ST_MISS;
				end else begin
					r.slot_index   = pos[SLOT_W-1:0];
					r.found_amount = amt_mem[pos];
					hit_count++;
				end
			end
			OP_REMOVE: begin
				if (pos < 0) begin
					r.status = ST_MISS;
				end else begin
					r.slot_index = pos[SLOT_W-1:0];
					sum = sum - {{(TOTAL_W-AMT_W){amt_mem[pos][AMT_W-1]}}, amt_mem[pos]};
					// The last record fills the hole so the table stays packed.
					key_mem[pos] = key_mem[used-1];
					amt_mem[pos] = amt_mem[used-1];
					used--;
					hit_count++;
				end
			end
			default: begin
				used = 0;
				sum  = '0;
			end
		endcase
		r.count_in_use = used[COUNT_W-1:0];
		r.total_amount = sum;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (mismatches < 20)
			$display("checker: %s mismatch, expected %0h, got %0h at %0t", what, want, got,
				$realtime);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		table_result_t want;
		if (!arst_n) begin
			used = 0;
			sum  = '0;
			results_due.delete();
			pending = 0;
		end else begin
			if (req.valid && req.ready)
				results_due.push_back(apply_request(op_t'(req.operation), req.key, req.amount));
			if (rsp.valid && rsp.ready) begin
				if (results_due.size() == 0) begin
					report_mismatch("unexpected result item", '0, {62'd0, rsp.status});
				end else begin
					want = results_due.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", want.status, rsp.status);
					if (rsp.slot_index !== want.slot_index)
						report_mismatch("slot_index", want.slot_index, rsp.slot_index);
					if (rsp.found_amount !== want.found_amount)
						report_mismatch("found_amount", want.found_amount, rsp.found_amount);
					if (rsp.count_in_use !== want.count_in_use)
						report_mismatch("count_in_use", want.count_in_use, rsp.count_in_use);
					if (rsp.total_amount !== want.total_amount)
						report_mismatch("total_amount", want.total_amount, rsp.total_amount);
				end
			end
			pending = results_due.size();
		end
	end

endmodule

### tb/tb.sv
// Top of the keyed record table testbench: clock, reset, request stimulus and the
// response-side stalls; the verdict comes from the failure count of krt_checker.
// Depends on krt_pkg, krt_req_if, krt_rsp_if, keyed_record_table and krt_checker.
module tb;
	import krt_pkg::*;

	localparam int CYCLE_LIMIT = 1_200_000;
	localparam int ITEM_GOAL   = 1300;

	logic        clk;
	logic        arst_n;
	int unsigned mismatches;
	int          pending;
	int unsigned hit_count;
	int unsigned full_count;
	int unsigned cycles;
	int unsigned items_sent;
	int unsigned ops_sent [4];
	bit          quiet;
	int          stall_left;
	logic [KEY_W-1:0] key_pool [24];

	krt_req_if req();
	krt_rsp_if rsp();

	keyed_record_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	krt_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.mismatches (mismatches),
		.pending    (pending),
		.hit_count  (hit_count),
		.full_count (full_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	// Mostly no gap, some short ones and a few long ones; none in quiet phases.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	initial begin
		rsp.ready  = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				rsp.ready = 1'b0;
				stall_left--;
			end else begin
				rsp.ready = 1'b1;
				if (!quiet && $urandom_range(0, 9) < 3)
					stall_left = pick_gap();
			end
		end
	end

	task automatic send_request(input op_t op, input logic [KEY_W-1:0] k,
			input logic [AMT_W-1:0] a);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid     = 1'b1;
		req.operation = op;
		req.key       = k;
		req.amount    = a;
		do
			@(posedge clk);
		while (!req.ready);
		@(negedge clk);
		ops_sent[op]++;
		items_sent++;
	endtask

	// Keys repeat often enough that finds and removes mostly hit.
	task automatic refresh_pool();
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hFFFF_FFFF;
		for (int i = 4; i < 24; i++)
			key_pool[i] = $urandom;
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 99) < 85)
			return key_pool[$urandom_range(0, 23)];
		return $urandom;
	endfunction

	function automatic logic [AMT_W-1:0] pick_amount();
		case ($urandom_range(0, 19))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic run_mixed(input int n, input int w_add, input int w_find, input int w_rem,
			input bit wild);
		int  r;
		op_t op;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < w_add)
				op = OP_ADD;
			else if (r < w_add + w_find)
				op = OP_FIND;
			else if (r < w_add + w_find + w_rem)
				op = OP_REMOVE;
			else
				op = OP_CLEAR;
			send_request(op, wild ? 32'($urandom) : pick_key(), pick_amount());
		end
	endtask

	// Fills the table past its size so that the last adds are refused, then runs finds and removes.
	task automatic run_fill(input bit use_fixed, input logic [AMT_W-1:0] fixed_amt);
		send_request(OP_CLEAR, $urandom, $urandom);
		repeat (SLOTS_DEF + 4)
			send_request(OP_ADD, pick_key(), use_fixed ? fixed_amt : pick_amount());
		run_mixed(20, 0, 50, 50, 1'b0);
	endtask

	initial begin
		arst_n        = 1'b0;
		req.valid     = 1'b0;
		req.operation = OP_ADD;
		req.key       = '0;
		req.amount    = '0;
		quiet         = 1'b0;
		items_sent    = 0;
		for (int i = 0; i < 4; i++)
			ops_sent[i] = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Lookups on an empty table, then extreme keys and amounts and a duplicate key.
		send_request(OP_FIND,   32'd5,        32'd0);
		send_request(OP_REMOVE, 32'd5,        32'd0);
		send_request(OP_ADD,    32'h8000_0000, 32'h7FFF_FFFF);
		send_request(OP_ADD,    32'h7FFF_FFFF, 32'h8000_0000);
		send_request(OP_ADD,    32'h0000_0000, 32'h0000_0000);
		send_request(OP_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(OP_ADD,    32'h7FFF_FFFF, 32'd1234);
		send_request(OP_FIND,   32'h7FFF_FFFF, 32'd0);
		send_request(OP_FIND,   32'h8000_0000, 32'd0);
		send_request(OP_FIND,   32'd12345,    32'd0);
		// Removing the first copy moves the last record into its slot.
		send_request(OP_REMOVE, 32'h7FFF_FFFF, 32'd0);
		send_request(OP_FIND,   32'h7FFF_FFFF, 32'd0);
		// The record with key -1 is now the last one and is moved onto itself.
		send_request(OP_REMOVE, 32'hFFFF_FFFF, 32'd0);
		send_request(OP_FIND,   32'h0000_0000, 32'd0);
		send_request(OP_REMOVE, 32'd12345,    32'd0);
		send_request(OP_CLEAR,  32'd0,        32'd0);
		send_request(OP_FIND,   32'h0000_0000, 32'd0);
		send_request(OP_ADD,    32'h5555_AAAA, 32'h5555_5555);
		send_request(OP_ADD,    32'hAAAA_5555, 32'hAAAA_AAAA);
		send_request(OP_REMOVE, 32'h5555_AAAA, 32'd0);
		send_request(OP_REMOVE, 32'hAAAA_5555, 32'd0);
		send_request(OP_CLEAR,  32'd0,        32'd0);

		// Full tables at both extremes of the running total come first.
		refresh_pool();
		run_fill(1'b1, 32'h7FFF_FFFF);
		quiet = 1'b1;
		refresh_pool();
		run_fill(1'b1, 32'h8000_0000);
		while (items_sent < ITEM_GOAL) begin
			quiet = ($urandom_range(0, 3) == 0);
			refresh_pool();
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: run_mixed($urandom_range(100, 200), 45, 25, 28, 1'b0);
				5, 6:          run_fill(1'($urandom_range(0, 1)), pick_amount());
				7:             run_mixed(40, 25, 25, 25, 1'b1);
				default:       run_mixed($urandom_range(30, 80), 20, 30, 50, 1'b0);
			endcase
		end
		req.valid = 1'b0;
		quiet     = 1'b0;

		wait (pending == 0);
		repeat (10) @(posedge clk);
		$display("tb: %0d requests: %0d add, %0d find, %0d remove, %0d clear", items_sent,
			ops_sent[OP_ADD], ops_sent[OP_FIND], ops_sent[OP_REMOVE], ops_sent[OP_CLEAR]);
		$display("tb: %0d lookups hit a record, %0d adds refused on a full table, %0d cycles",
			hit_count, full_count, cycles);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/krt_pkg.sv
rtl/krt_req_if.sv
rtl/krt_rsp_if.sv
rtl/krt_total.sv
rtl/keyed_record_table.sv
rtl/krt_checker.sv
tb/krt_checker.sv
tb/tb.sv
